[hdl/aes128_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 package
// S-box tables, field helpers and shared types for the round pipeline.
// ----------------------------------------------------------------------------
package aes128_pkg;

	localparam int NumRounds = 10;
	localparam int RegIdxW = 1;

	localparam logic [RegIdxW-1:0] RegKeyHigh = 1'b0;
	localparam logic [RegIdxW-1:0] RegKeyLow = 1'b1;

	typedef logic [7:0] byte_t;
	typedef logic [127:0] block_t;

	typedef struct packed {
		logic   valid;
		logic   encrypt;
	} ctrl_t;

	function automatic byte_t xtime(byte_t a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic byte_t gmul(byte_t a, byte_t b);
		byte_t acc;
		byte_t p;
		acc = 8'h00;
		p = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc = acc ^ p;
			p = xtime(p);
		end
		gmul = acc;
	endfunction

	function automatic byte_t sbox(byte_t a);
		byte_t t [256] = '{
			8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
			8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
			8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
			8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
			8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
			8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
			8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
			8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
			8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
			8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
			8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
			8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
			8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
			8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
			8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
			8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		sbox = t[a];
	endfunction

	function automatic byte_t inv_sbox(byte_t a);
		byte_t t [256] = '{
			8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
			8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
			8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
			8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
			8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
			8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
			8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
			8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
			8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
			8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
			8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
			8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
			8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
			8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
			8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
			8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		inv_sbox = t[a];
	endfunction

	// Byte n of a block (n = column * 4 + row) sits in bits 127-8n downward.
	function automatic byte_t get_byte(block_t b, int n);
		get_byte = b[127 - 8 * n -: 8];
	endfunction

	// Rcon of round r (1 to 10) is x^(r-1) in the field.
	function automatic byte_t rcon(int r);
		byte_t v;
		v = 8'h01;
		for (int i = 1; i < r; i++) v = xtime(v);
		rcon = v;
	endfunction

	// Next round key from the previous one, for round r.
	function automatic block_t next_key(block_t k, int r);
		logic [31:0] w [4];
		logic [31:0] t;
		for (int i = 0; i < 4; i++) w[i] = k[127 - 32 * i -: 32];
		t = {sbox(w[3][23:16]) ^ rcon(r), sbox(w[3][15:8]), sbox(w[3][7:0]),
			sbox(w[3][31:24])};
		w[0] = w[0] ^ t;
		w[1] = w[1] ^ w[0];
		w[2] = w[2] ^ w[1];
		w[3] = w[3] ^ w[2];
		next_key = {w[0], w[1], w[2], w[3]};
	endfunction

endpackage

[hdl/aes128_round_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 round cell
// One registered cipher round, forward or inverse, chosen per item.
// ----------------------------------------------------------------------------
module aes128_round_cell #(
	parameter int Round = 1,
	parameter int Rounds = aes128_pkg::NumRounds
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  aes128_pkg::ctrl_t       ctrl_in,
	input  aes128_pkg::block_t      state_in,
	input  aes128_pkg::block_t      enc_key,
	input  aes128_pkg::block_t      dec_key,
	output aes128_pkg::ctrl_t       ctrl_out,
	output aes128_pkg::block_t      state_out
);

	localparam bit Last = (Round == Rounds);

	aes128_pkg::block_t enc_v;
	aes128_pkg::block_t dec_v;
	aes128_pkg::ctrl_t  ctrl_s1;
	aes128_pkg::block_t state_s1;

	always_comb begin
		aes128_pkg::byte_t sb [16];
		aes128_pkg::byte_t ib [16];
		aes128_pkg::byte_t t [16];
		aes128_pkg::byte_t u [16];
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				sb[r + 4 * c] = aes128_pkg::sbox(
					aes128_pkg::get_byte(state_in, r + 4 * ((c + r) % 4)));
				ib[r + 4 * ((c + r) % 4)] = aes128_pkg::inv_sbox(
					aes128_pkg::get_byte(state_in, r + 4 * c));
			end
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[4 * c + r] = 8'h00;
				for (int k = 0; k < 4; k++) begin
					t[4 * c + r] = t[4 * c + r] ^ aes128_pkg::gmul(sb[4 * c + k],
						(((k - r + 4) % 4) == 0) ? 8'd2 :
						(((k - r + 4) % 4) == 1) ? 8'd3 : 8'd1);
				end
			end
		end
		for (int n = 0; n < 16; n++) begin
			enc_v[127 - 8 * n -: 8] = (Last ? sb[n] : t[n]) ^
				aes128_pkg::get_byte(enc_key, n);
			ib[n] = ib[n] ^ aes128_pkg::get_byte(dec_key, n);
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				u[4 * c + r] = 8'h00;
				for (int k = 0; k < 4; k++) begin
					u[4 * c + r] = u[4 * c + r] ^ aes128_pkg::gmul(ib[4 * c + k],
						(((k - r + 4) % 4) == 0) ? 8'd14 :
						(((k - r + 4) % 4) == 1) ? 8'd11 :
						(((k - r + 4) % 4) == 2) ? 8'd13 : 8'd9);
				end
			end
		end
		for (int n = 0; n < 16; n++) begin
			dec_v[127 - 8 * n -: 8] = Last ? ib[n] : u[n];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (adv) begin
			ctrl_s1 <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			state_s1 <= ctrl_in.encrypt ? enc_v : dec_v;
		end
	end

	assign ctrl_out = ctrl_s1;
	assign state_out = state_s1;

endmodule

[hdl/aes128_block_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Ten chained round cells encrypt or decrypt one block per cycle unless stalled.
// ----------------------------------------------------------------------------
//  Channel  | Handshake          | Payload
//  input    | valid / stall      | operation, block_high, block_low
//  output   | out_valid / out_stall | result_high, result_low
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// An item passes the initial key add stage, then one stage per round cell. A
// new item enters every cycle unless the input is stalled. A stall on the
// output with out_valid high freezes the whole row and stalls the input.
// Reset clears the keys and the valid bits. The round keys are rebuilt one step
// per cycle, so the input is stalled after reset and after each key write.
module aes128_block_cipher #(
	parameter int Rounds = aes128_pkg::NumRounds
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid,
	output logic                          stall,
	input  logic                          operation,
	input  logic [63:0]                   block_high,
	input  logic [63:0]                   block_low,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [63:0]                   result_high,
	output logic [63:0]                   result_low,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [aes128_pkg::RegIdxW-1:0] cfg_index,
	input  logic [63:0]                   cfg_data
);

	aes128_pkg::block_t key_q;
	aes128_pkg::block_t rk [Rounds + 1];
	aes128_pkg::block_t rk_q [Rounds + 1];
	aes128_pkg::ctrl_t  ctrl [Rounds + 1];
	aes128_pkg::block_t st [Rounds + 1];
	aes128_pkg::ctrl_t  ctrl_s0;
	aes128_pkg::block_t state_s0;
	logic               adv;
	logic [3:0]         settle_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				aes128_pkg::RegKeyHigh: key_q[127:64] <= cfg_data;
				aes128_pkg::RegKeyLow:  key_q[63:0] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Key schedule: one expansion step per register, refreshed every cycle.
	assign rk[0] = key_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= Rounds; i++) rk_q[i] <= '0;
		end else begin
			rk_q[0] <= key_q;
			for (int i = 1; i <= Rounds; i++) rk_q[i] <= aes128_pkg::next_key(rk_q[i - 1], i);
		end
	end
	for (genvar i = 1; i <= Rounds; i++) begin : g_rk
		assign rk[i] = rk_q[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 4'(Rounds + 1);
		end else if (cfg_valid && cfg_ready) begin
			settle_q <= 4'(Rounds + 1);
		end else if (settle_q != 4'd0) begin
			settle_q <= settle_q - 4'd1;
		end
	end

	assign adv = !(out_valid && out_stall);
	assign stall = !adv || (settle_q != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s0 <= '0;
		end else if (adv) begin
			ctrl_s0 <= '{valid: valid && (settle_q == 4'd0), encrypt: operation};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			state_s0 <= {block_high, block_low} ^ (operation ? rk[0] : rk[Rounds]);
		end
	end

	assign ctrl[0] = ctrl_s0;
	assign st[0] = state_s0;

	for (genvar i = 1; i <= Rounds; i++) begin : g_cell
		aes128_round_cell #(.Round(i), .Rounds(Rounds)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.ctrl_in  (ctrl[i - 1]),
			.state_in (st[i - 1]),
			.enc_key  (rk[i]),
			.dec_key  (rk[Rounds - i]),
			.ctrl_out (ctrl[i]),
			.state_out(st[i])
		);
	end

	assign out_valid = ctrl[Rounds].valid;
	assign result_high = st[Rounds][127:64];
	assign result_low = st[Rounds][63:0];

endmodule
